### hw/rtl/gbfp_pkg.sv
// Shared constants, types and helpers for the binary GPS frame parser.
package gbfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] POS_CLASS   = 8'h01;
    localparam logic [7:0] POS_ID      = 8'h05;

    localparam int PAYLOAD_LEN = 26;
    localparam int CNT_W       = 5;

    // Decoded payload words held in the field RAM, one bank per frame buffer.
    localparam int FIELD_W   = 32;
    localparam int WORDS     = 7;
    localparam int WIDX_W    = $clog2(WORDS);
    localparam int RAM_DEPTH = 2 * (1 << WIDX_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam logic [WIDX_W-1:0] W_LON    = WIDX_W'(0);
    localparam logic [WIDX_W-1:0] W_LAT    = WIDX_W'(1);
    localparam logic [WIDX_W-1:0] W_ALT    = WIDX_W'(2);
    localparam logic [WIDX_W-1:0] W_SPEED  = WIDX_W'(3);
    localparam logic [WIDX_W-1:0] W_COURSE = WIDX_W'(4);
    localparam logic [WIDX_W-1:0] W_SATFIX = WIDX_W'(5);
    localparam logic [WIDX_W-1:0] W_TIME   = WIDX_W'(6);
    localparam logic [WIDX_W-1:0] W_LAST   = W_TIME;

    // Payload byte that closes the satellite/fix pair.
    localparam logic [CNT_W-1:0] FIX_BYTE = CNT_W'(21);

    typedef enum logic [6:0] {
        ST_SYNC1   = 7'b0000001,
        ST_SYNC2   = 7'b0000010,
        ST_CLASS   = 7'b0000100,
        ST_ID      = 7'b0001000,
        ST_PAYLOAD = 7'b0010000,
        ST_CKA     = 7'b0100000,
        ST_CKB     = 7'b1000000
    } t_step;

    typedef struct packed {
        logic                 we;
        logic [RAM_AW-1:0]    addr;
        logic [FIELD_W-1:0]   data;
    } t_ram_wr;

    typedef struct packed {
        logic done;
        logic ok;
        logic pos;
    } t_frame_end;

    typedef struct packed {
        logic busy;
    } t_fetch_stat;

    // Payload byte positions that complete a stored word.
    function automatic logic word_end(input logic [CNT_W-1:0] cnt);
        logic hit;
        case (cnt) inside
            5'd3, 5'd7, 5'd11, 5'd15, 5'd19, 5'd21, 5'd25: hit = 1'b1;
            default:                                     hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [WIDX_W-1:0] word_idx(input logic [CNT_W-1:0] cnt);
        logic [WIDX_W-1:0] idx;
        case (cnt)
            5'd3:    idx = W_LON;
            5'd7:    idx = W_LAT;
            5'd11:   idx = W_ALT;
            5'd15:   idx = W_SPEED;
            5'd19:   idx = W_COURSE;
            5'd21:   idx = W_SATFIX;
            5'd25:   idx = W_TIME;
            default: idx = W_LON;
        endcase
        return idx;
    endfunction

endpackage

### hw/rtl/gbfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/gbfp_frame.sv
// Byte-level frame tracker: sync hunt, Fletcher sums, payload word assembly.
module gbfp_frame import gbfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    output logic        o_stall,
    input  logic        i_cbank,
    input  t_fetch_stat i_fetch,
    output t_ram_wr     o_ram_wr,
    output t_frame_end  o_fend
);

    t_step             r_step,  n_step;
    logic [7:0]        r_cls,   n_cls;
    logic [7:0]        r_id,    n_id;
    logic [7:0]        r_sa,    n_sa;
    logic [7:0]        r_sb,    n_sb;
    logic [7:0]        r_rxa,   n_rxa;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic [31:0]       r_word,  n_word;
    logic              accept;
    logic              sum_ok;

    // Hold the closing checksum byte while the previous result is in flight.
    assign o_stall = (r_step == ST_CKB) && i_fetch.busy;
    assign accept  = i_valid && !o_stall;
    assign sum_ok  = (r_rxa == r_sa) && (i_data_byte == r_sb);

    always_comb begin
        n_step   = r_step;
        n_cls    = r_cls;
        n_id     = r_id;
        n_sa     = r_sa;
        n_sb     = r_sb;
        n_rxa    = r_rxa;
        n_cnt    = r_cnt;
        n_word   = r_word;
        o_ram_wr = '0;
        o_fend   = '0;
        if (accept) begin
            unique case (r_step)
                ST_SYNC1: begin
                    if (i_data_byte == SYNC_FIRST) begin
                        n_step = ST_SYNC2;
                    end
                end
                ST_SYNC2: begin
                    n_step = (i_data_byte == SYNC_SECOND) ? ST_CLASS : ST_SYNC1;
                end
                ST_CLASS: begin
                    n_cls  = i_data_byte;
                    n_sa   = r_sa + i_data_byte;
                    n_sb   = r_sb + n_sa;
                    n_step = ST_ID;
                end
                ST_ID: begin
                    n_id   = i_data_byte;
                    n_sa   = r_sa + i_data_byte;
                    n_sb   = r_sb + n_sa;
                    n_cnt  = '0;
                    n_step = ST_PAYLOAD;
                end
                ST_PAYLOAD: begin
                    n_word = {r_word[23:0], i_data_byte};
                    n_sa   = r_sa + i_data_byte;
                    n_sb   = r_sb + n_sa;
                    n_cnt  = r_cnt + CNT_W'(1);
                    if (word_end(r_cnt)) begin
                        o_ram_wr.we   = 1'b1;
                        o_ram_wr.addr = {~i_cbank, word_idx(r_cnt)};
                        o_ram_wr.data = (r_cnt == FIX_BYTE) ? {16'h0000, n_word[15:0]}
                                                             : n_word;
                    end
                    if (r_cnt == CNT_W'(PAYLOAD_LEN - 1)) begin
                        n_step = ST_CKA;
                    end
                end
                ST_CKA: begin
                    n_rxa  = i_data_byte;
                    n_step = ST_CKB;
                end
                ST_CKB: begin
                    o_fend.done = 1'b1;
                    o_fend.ok   = sum_ok;
                    o_fend.pos  = sum_ok && (r_cls == POS_CLASS) && (r_id == POS_ID);
                    n_step = ST_SYNC1;
                    n_cls  = '0;
                    n_id   = '0;
                    n_sa   = '0;
                    n_sb   = '0;
                    n_rxa  = '0;
                    n_cnt  = '0;
                end
                default: begin
                    n_step = ST_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_SYNC1;
            r_cls  <= '0;
            r_id   <= '0;
            r_sa   <= '0;
            r_sb   <= '0;
            r_rxa  <= '0;
            r_cnt  <= '0;
        end else begin
            r_step <= n_step;
            r_cls  <= n_cls;
            r_id   <= n_id;
            r_sa   <= n_sa;
            r_sb   <= n_sb;
            r_rxa  <= n_rxa;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

### hw/rtl/gbfp_fetch.sv
// Bank commit and result sequencer: reads the committed field words into the output register.
module gbfp_fetch import gbfp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_frame_end         i_fend,
    input  logic [FIELD_W-1:0] i_rdata,
    input  logic               i_out_stall,
    output logic               o_re,
    output logic [RAM_AW-1:0]  o_raddr,
    output logic               o_cbank,
    output t_fetch_stat        o_stat,
    output logic               o_out_valid,
    output logic               o_checksum_ok,
    output logic               o_position_valid,
    output logic signed [31:0] o_longitude,
    output logic signed [31:0] o_latitude,
    output logic signed [31:0] o_altitude_value,
    output logic signed [31:0] o_ground_speed,
    output logic signed [31:0] o_ground_course,
    output logic [7:0]         o_satellite_count,
    output logic [7:0]         o_fix_kind,
    output logic signed [31:0] o_fix_time
);

    logic              r_cbank;
    logic              r_have;
    logic              r_rd_act;
    logic [WIDX_W-1:0] r_rd_idx;
    logic              r_cap_vld;
    logic [WIDX_W-1:0] r_cap_idx;
    logic              r_out_valid;
    logic              r_ok;
    logic              r_pos;
    logic [31:0]       r_lon, r_lat, r_alt, r_speed, r_course, r_time;
    logic [7:0]        r_sats, r_fix;
    logic [FIELD_W-1:0] cap_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbank     <= 1'b0;
            r_have      <= 1'b0;
            r_rd_act    <= 1'b0;
            r_rd_idx    <= '0;
            r_cap_vld   <= 1'b0;
            r_cap_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_fend.done) begin
                r_rd_act <= 1'b1;
                r_rd_idx <= '0;
                if (i_fend.pos) begin
                    r_cbank <= ~r_cbank;
                    r_have  <= 1'b1;
                end
            end else if (r_rd_act) begin
                if (r_rd_idx == W_LAST) begin
                    r_rd_act <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + WIDX_W'(1);
                end
            end
            r_cap_vld <= r_rd_act;
            r_cap_idx <= r_rd_idx;
            if (r_cap_vld && (r_cap_idx == W_LAST)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // No commit since reset: fields read as zero.
    assign cap_data = r_have ? i_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (i_fend.done) begin
            r_ok  <= i_fend.ok;
            r_pos <= i_fend.pos;
        end
        if (r_cap_vld) begin
            case (r_cap_idx)
                W_LON:    r_lon    <= cap_data;
                W_LAT:    r_lat    <= cap_data;
                W_ALT:    r_alt    <= cap_data;
                W_SPEED:  r_speed  <= cap_data;
                W_COURSE: r_course <= cap_data;
                W_SATFIX: begin
                    r_sats <= cap_data[15:8];
                    r_fix  <= cap_data[7:0];
                end
                W_TIME:   r_time   <= cap_data;
                default:  ;
            endcase
        end
    end

    assign o_re        = r_rd_act;
    assign o_raddr     = {r_cbank, r_rd_idx};
    assign o_cbank     = r_cbank;
    assign o_stat.busy = r_rd_act || r_cap_vld || r_out_valid;

    assign o_out_valid       = r_out_valid;
    assign o_checksum_ok     = r_ok;
    assign o_position_valid  = r_pos;
    assign o_longitude       = r_lon;
    assign o_latitude        = r_lat;
    assign o_altitude_value  = r_alt;
    assign o_ground_speed    = r_speed;
    assign o_ground_course   = r_course;
    assign o_satellite_count = r_sats;
    assign o_fix_kind        = r_fix;
    assign o_fix_time        = r_time;

endmodule

### hw/rtl/gps_binary_frame_parser.sv
// Top level of the binary GPS frame parser.
//
// Input channel: one received serial byte per transfer (i_in_valid, o_in_stall,
// i_data_byte). Output channel: one result per complete frame (o_out_valid,
// i_out_stall and the field ports), carrying the checksum verdict, the
// position-valid flag and the last committed position fields.
//
// Throughput: one byte per cycle. Payload words are assembled on the fly and
// written into one bank of a two-bank field RAM; a frame with a good checksum
// and class 1 / id 5 flips the committed bank pointer.
// After the last checksum byte, the sequencer reads the seven committed words
// through the RAM read port into the output registers, then flags the result.
// The input stalls only on a frame's last checksum byte while the previous
// result is still being fetched or waits at the output (frames are at least
// 32 bytes apart, so a ready receiver never sees this).
// Reset: hunt for the first sync byte, sums cleared, no bank committed, so
// fields read as zero until the first good position frame. No clearing pass.
// A stalled result holds all of its fields.
module gps_binary_frame_parser import gbfp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_checksum_ok,
    output logic               o_position_valid,
    output logic signed [31:0] o_longitude,
    output logic signed [31:0] o_latitude,
    output logic signed [31:0] o_altitude_value,
    output logic signed [31:0] o_ground_speed,
    output logic signed [31:0] o_ground_course,
    output logic [7:0]         o_satellite_count,
    output logic [7:0]         o_fix_kind,
    output logic signed [31:0] o_fix_time
);

    t_ram_wr            ram_wr;
    t_frame_end         fend;
    t_fetch_stat        stat;
    logic               ram_re;
    logic [RAM_AW-1:0]  ram_raddr;
    logic [FIELD_W-1:0] ram_rdata;
    logic               cbank;

    // Byte tracker: sync, sums, word writes into the uncommitted bank.
    gbfp_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_data_byte (i_data_byte),
        .o_stall     (o_in_stall),
        .i_cbank     (cbank),
        .i_fetch     (stat),
        .o_ram_wr    (ram_wr),
        .o_fend      (fend)
    );

    // Field store: two banks of decoded words.
    gbfp_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (RAM_DEPTH)
    ) u_field_ram (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Commit and result fetch.
    gbfp_fetch u_fetch (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fend            (fend),
        .i_rdata           (ram_rdata),
        .i_out_stall       (i_out_stall),
        .o_re              (ram_re),
        .o_raddr           (ram_raddr),
        .o_cbank           (cbank),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .o_checksum_ok     (o_checksum_ok),
        .o_position_valid  (o_position_valid),
        .o_longitude       (o_longitude),
        .o_latitude        (o_latitude),
        .o_altitude_value  (o_altitude_value),
        .o_ground_speed    (o_ground_speed),
        .o_ground_course   (o_ground_course),
        .o_satellite_count (o_satellite_count),
        .o_fix_kind        (o_fix_kind),
        .o_fix_time        (o_fix_time)
    );

    // A frame end never lands on a result still in flight.
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fend.done |-> !stat.busy)
        else $error("frame end while fetch busy");

    // A frame end always starts the fetch.
    a_end_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fend.done |=> (ram_re && stat.busy))
        else $error("fetch not started after frame end");

    // Word writes never hit the bank being read.
    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_wr.we && ram_re) |-> (ram_wr.addr[RAM_AW-1] != ram_raddr[RAM_AW-1]))
        else $error("field RAM bank collision");

endmodule
